@@ hdl/assert_macros.svh @@
// Assertion macros for the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Assertion that is switched off while reset is applied
`define ASSERT_RST(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
// Assertion that also holds through reset
`define ASSERT_ALL(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);
`endif

@@ hdl/cmbb_pkg.sv @@
// Shared types, constants and register indexes for the circle masked box blur
`timescale 1ns / 1ps
`default_nettype none
package cmbb_pkg;
    localparam int DEF_MAX_WIDTH  = 1024;
    localparam int DEF_MAX_HEIGHT = 1024;
    localparam int DEF_MAX_RADIUS = 7;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 11;

    localparam logic [CFG_IDX_W-1:0] REG_IMG_WIDTH     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_IMG_HEIGHT    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_BOX_RADIUS    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_CENTER_ROW    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_CENTER_COL    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_CIRCLE_RADIUS = 3'd5;

    localparam logic KIND_PIXEL = 1'b0;
    localparam logic KIND_DRAIN = 1'b1;

    typedef struct packed {
        logic       kind;
        logic [7:0] pixel;
    } in_word_t;

    typedef struct packed {
        logic [7:0] out_pixel;
        logic       frame_last;
    } out_word_t;

    // circle parameters handed to the back end
    typedef struct packed {
        logic [9:0]  center_row;
        logic [9:0]  center_col;
        logic [10:0] circle_radius;
    } circle_cfg_t;
endpackage
`default_nettype wire

@@ hdl/cmbb_queue.sv @@
// Two-entry queue between front end and back end
`timescale 1ns / 1ps
`default_nettype none
module cmbb_queue #(
    parameter int WIDTH = 8
) (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             push,
    input  wire logic [WIDTH-1:0] push_data,
    output logic                  full,
    input  wire logic             pop,
    output logic [WIDTH-1:0]      pop_data,
    output logic                  empty
);
    logic [WIDTH-1:0] slot0_reg, slot1_reg;
    logic [1:0]       count_reg, count_next;

    assign full     = (count_reg == 2'd2);
    assign empty    = (count_reg == 2'd0);
    assign pop_data = slot0_reg;

    // track fill level
    always_comb begin
        count_next = count_reg;
        if (push && !pop) count_next = count_reg + 2'd1;
        else if (pop && !push) count_next = count_reg - 2'd1;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= 2'd0;
        end else begin
            count_reg <= count_next;
        end
    end

    // shift the head out on pop, land the new word behind the rest
    always_ff @(posedge aclk) begin
        if (pop) begin
            slot0_reg <= slot1_reg;
            if (push && count_reg == 2'd1) slot0_reg <= push_data;
            if (push && count_reg == 2'd2) slot1_reg <= push_data;
        end else if (push) begin
            if (count_reg == 2'd0) slot0_reg <= push_data;
            else slot1_reg <= push_data;
        end
    end
endmodule
`default_nettype wire

@@ hdl/cmbb_front.sv @@
// Front end: configuration, stream positions and work classification
`timescale 1ns / 1ps
`default_nettype none
module cmbb_front
    import cmbb_pkg::*;
#(
    parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = DEF_MAX_HEIGHT,
    parameter int MAX_RADIUS = DEF_MAX_RADIUS,
    parameter int ENTRY_W    = 8
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  s_valid,
    output logic                       s_ready,
    input  wire in_word_t              s_data,
    input  wire logic                  cfg_valid,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data,
    output circle_cfg_t                circ,
    output logic                       push,
    output logic [ENTRY_W-1:0]         push_data,
    input  wire logic                  full
);
    localparam int LS_ROWS = 2 * MAX_RADIUS + 2;
    localparam int SLOT_W  = $clog2(LS_ROWS);
    localparam int COL_W   = $clog2(MAX_WIDTH);
    localparam int ROW_W   = $clog2(MAX_HEIGHT + 1);
    localparam int DW      = $clog2(MAX_WIDTH + 1);
    localparam int RAD_W   = $clog2(MAX_RADIUS + 1);
    localparam int NY_W    = $clog2(2 * MAX_RADIUS + 2);
    localparam int LAG_W   = $clog2(MAX_RADIUS * MAX_WIDTH + MAX_RADIUS + 1);

    typedef struct packed {
        logic              we;
        logic [SLOT_W-1:0] wslot;
        logic [COL_W-1:0]  wcol;
        logic [7:0]        pix;
        logic              job;
        logic [SLOT_W-1:0] pslot;
        logic [ROW_W-1:0]  row;
        logic [COL_W-1:0]  col;
        logic [SLOT_W-1:0] tslot;
        logic [NY_W-1:0]   ny;
        logic [COL_W-1:0]  x0;
        logic [NY_W-1:0]   nx;
        logic              last;
    } entry_t;

    entry_t entry;

    logic [10:0] img_width_reg, img_height_reg, circle_radius_reg;
    logic [2:0]  box_radius_reg;
    logic [9:0]  center_row_reg, center_col_reg;

    logic [ROW_W-1:0]  in_row_reg, in_row_next, out_row_reg, out_row_next;
    logic [COL_W-1:0]  in_col_reg, in_col_next, out_col_reg, out_col_next;
    logic [SLOT_W-1:0] in_slot_reg, in_slot_next, out_slot_reg, out_slot_next;
    logic [LAG_W-1:0]  ahead_reg, ahead_next;

    logic [31:0]       w_full, h_full, rad_full;
    logic [DW-1:0]     w;
    logic [ROW_W-1:0]  h;
    logic [RAD_W-1:0]  rad;
    logic [LAG_W-1:0]  lag;
    logic              accept, in_active, advance, emit, last;
    logic [ROW_W-1:0]  below;
    logic [DW-1:0]     right_room;
    logic [RAD_W-1:0]  up, dn, left, right;

    // clamp configured sizes
    always_comb begin
        w_full   = (img_width_reg == 11'd0) ? 32'd1 :
                   ({21'd0, img_width_reg} > 32'(MAX_WIDTH)) ? 32'(MAX_WIDTH) :
                   {21'd0, img_width_reg};
        h_full   = (img_height_reg == 11'd0) ? 32'd1 :
                   ({21'd0, img_height_reg} > 32'(MAX_HEIGHT)) ? 32'(MAX_HEIGHT) :
                   {21'd0, img_height_reg};
        rad_full = ({29'd0, box_radius_reg} > 32'(MAX_RADIUS)) ? 32'(MAX_RADIUS) :
                   {29'd0, box_radius_reg};
        w   = w_full[DW-1:0];
        h   = h_full[ROW_W-1:0];
        rad = rad_full[RAD_W-1:0];
        lag = LAG_W'(rad) * LAG_W'(w) + LAG_W'(rad);
    end

    assign s_ready = !full;
    assign accept  = s_valid && s_ready;
    assign circ    = '{center_row: center_row_reg, center_col: center_col_reg,
                       circle_radius: circle_radius_reg};

    // classify the word and step the positions
    always_comb begin
        in_active = (in_row_reg < h);
        advance   = !(in_active && s_data.kind == KIND_DRAIN);
        emit      = advance && (ahead_reg == lag);
        last      = (out_row_reg == h - ROW_W'(1)) &&
                    ({{(DW-COL_W){1'b0}}, out_col_reg} == w - DW'(1));

        in_row_next   = in_row_reg;
        in_col_next   = in_col_reg;
        in_slot_next  = in_slot_reg;
        out_row_next  = out_row_reg;
        out_col_next  = out_col_reg;
        out_slot_next = out_slot_reg;
        ahead_next    = ahead_reg;

        if (accept && advance) begin
            if ({{(DW-COL_W){1'b0}}, in_col_reg} + DW'(1) >= w) begin
                in_col_next  = '0;
                in_row_next  = in_row_reg + ROW_W'(1);
                in_slot_next = (in_slot_reg == SLOT_W'(LS_ROWS - 1)) ? '0
                             : in_slot_reg + SLOT_W'(1);
            end else begin
                in_col_next = in_col_reg + COL_W'(1);
            end
            if (!emit) begin
                ahead_next = ahead_reg + LAG_W'(1);
            end else if (last) begin
                in_row_next   = '0;
                in_col_next   = '0;
                in_slot_next  = '0;
                out_row_next  = '0;
                out_col_next  = '0;
                out_slot_next = '0;
                ahead_next    = '0;
            end else if ({{(DW-COL_W){1'b0}}, out_col_reg} + DW'(1) >= w) begin
                out_col_next  = '0;
                out_row_next  = out_row_reg + ROW_W'(1);
                out_slot_next = (out_slot_reg == SLOT_W'(LS_ROWS - 1)) ? '0
                              : out_slot_reg + SLOT_W'(1);
            end else begin
                out_col_next = out_col_reg + COL_W'(1);
            end
        end
    end

    // box extent around the output pixel, clipped at the frame edges
    always_comb begin
        below      = h - ROW_W'(1) - out_row_reg;
        right_room = w - DW'(1) - {{(DW-COL_W){1'b0}}, out_col_reg};
        up    = (out_row_reg < ROW_W'(rad)) ? out_row_reg[RAD_W-1:0] : rad;
        dn    = (below < ROW_W'(rad)) ? below[RAD_W-1:0] : rad;
        left  = (out_col_reg < COL_W'(rad)) ? out_col_reg[RAD_W-1:0] : rad;
        right = (right_room < DW'(rad)) ? right_room[RAD_W-1:0] : rad;

        entry.we    = in_active;
        entry.wslot = in_slot_reg;
        entry.wcol  = in_col_reg;
        entry.pix   = s_data.pixel;
        entry.job   = emit;
        entry.pslot = out_slot_reg;
        entry.row   = out_row_reg;
        entry.col   = out_col_reg;
        entry.tslot = (out_slot_reg >= SLOT_W'(up)) ? out_slot_reg - SLOT_W'(up)
                    : out_slot_reg + SLOT_W'(LS_ROWS) - SLOT_W'(up);
        entry.ny    = NY_W'(up) + NY_W'(dn) + NY_W'(1);
        entry.x0    = out_col_reg - COL_W'(left);
        entry.nx    = NY_W'(left) + NY_W'(right) + NY_W'(1);
        entry.last  = last;
    end

    assign push      = accept && (in_active && advance || emit);
    assign push_data = ENTRY_W'(entry);

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            img_width_reg     <= 11'd256;
            img_height_reg    <= 11'd256;
            box_radius_reg    <= 3'd1;
            center_row_reg    <= 10'd128;
            center_col_reg    <= 10'd128;
            circle_radius_reg <= 11'd64;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                REG_IMG_WIDTH:     img_width_reg     <= cfg_data;
                REG_IMG_HEIGHT:    img_height_reg    <= cfg_data;
                REG_BOX_RADIUS:    box_radius_reg    <= cfg_data[2:0];
                REG_CENTER_ROW:    center_row_reg    <= cfg_data[9:0];
                REG_CENTER_COL:    center_col_reg    <= cfg_data[9:0];
                REG_CIRCLE_RADIUS: circle_radius_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // positions; a known register write restarts the frame
    always_ff @(posedge aclk) begin
        if (!aresetn || (cfg_valid && cfg_index <= REG_CIRCLE_RADIUS)) begin
            in_row_reg   <= '0;
            in_col_reg   <= '0;
            in_slot_reg  <= '0;
            out_row_reg  <= '0;
            out_col_reg  <= '0;
            out_slot_reg <= '0;
            ahead_reg    <= '0;
        end else begin
            in_row_reg   <= in_row_next;
            in_col_reg   <= in_col_next;
            in_slot_reg  <= in_slot_next;
            out_row_reg  <= out_row_next;
            out_col_reg  <= out_col_next;
            out_slot_reg <= out_slot_next;
            ahead_reg    <= ahead_next;
        end
    end
endmodule
`default_nettype wire

@@ hdl/cmbb_back.sv @@
// Back end: line store, box sum, circle test, divider and result register
`timescale 1ns / 1ps
`default_nettype none
module cmbb_back
    import cmbb_pkg::*;
#(
    parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = DEF_MAX_HEIGHT,
    parameter int MAX_RADIUS = DEF_MAX_RADIUS,
    parameter int ENTRY_W    = 8
) (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire circle_cfg_t        circ,
    input  wire logic [ENTRY_W-1:0] pop_data,
    input  wire logic               empty,
    output logic                    pop,
    output logic                    m_valid,
    input  wire logic               m_ready,
    output out_word_t               m_data
);
    localparam int LS_ROWS = 2 * MAX_RADIUS + 2;
    localparam int SLOT_W  = $clog2(LS_ROWS);
    localparam int COL_W   = $clog2(MAX_WIDTH);
    localparam int ROW_W   = $clog2(MAX_HEIGHT + 1);
    localparam int NY_W    = $clog2(2 * MAX_RADIUS + 2);
    localparam int CNT_W   = $clog2((2 * MAX_RADIUS + 1) * (2 * MAX_RADIUS + 1) + 1);
    localparam int SUM_W   = $clog2(255 * (2 * MAX_RADIUS + 1) * (2 * MAX_RADIUS + 1) + 1);
    localparam int DIV_W   = $clog2(SUM_W + 1);
    localparam int DV_A    = (ROW_W > COL_W) ? ROW_W : COL_W;
    localparam int DV_W    = (DV_A > 10) ? DV_A : 10;
    localparam int D2_A    = 2 * DV_W + 1;
    localparam int D2_W    = (D2_A > 22) ? D2_A : 22;

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_READ  = 3'd1;
    localparam logic [2:0] ST_CTR   = 3'd2;
    localparam logic [2:0] ST_CWAIT = 3'd3;
    localparam logic [2:0] ST_DIV   = 3'd4;
    localparam logic [2:0] ST_OUT   = 3'd5;

    typedef struct packed {
        logic              we;
        logic [SLOT_W-1:0] wslot;
        logic [COL_W-1:0]  wcol;
        logic [7:0]        pix;
        logic              job;
        logic [SLOT_W-1:0] pslot;
        logic [ROW_W-1:0]  row;
        logic [COL_W-1:0]  col;
        logic [SLOT_W-1:0] tslot;
        logic [NY_W-1:0]   ny;
        logic [COL_W-1:0]  x0;
        logic [NY_W-1:0]   nx;
        logic              last;
    } entry_t;

    entry_t head, job_reg;

    logic [7:0] line_mem [LS_ROWS][MAX_WIDTH];
    logic [7:0] rd_data_reg;

    logic [2:0]        state_reg;
    logic [SLOT_W-1:0] slot_reg, rd_slot;
    logic [COL_W-1:0]  x_reg, rd_col;
    logic [NY_W-1:0]   xcnt_reg, ycnt_reg;
    logic              acc_en_reg;
    logic [SUM_W-1:0]  sum_reg, quo_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic [CNT_W:0]    rem_reg, rem_shift;
    logic [DIV_W-1:0]  step_reg;
    logic [7:0]        center_reg;
    logic              inside_reg;
    logic [DV_W-1:0]   dr_reg, dc_reg, row_ext, col_ext, crow_ext, ccol_ext;
    logic [2*DV_W-1:0] dr2_reg, dc2_reg;
    logic [21:0]       rr_reg;
    logic              m_valid_reg;
    out_word_t         m_data_reg;

    assign head    = entry_t'(pop_data);
    assign pop     = (state_reg == ST_IDLE) && !empty;
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // line store: one write, one registered read
    assign rd_slot = (state_reg == ST_CTR) ? job_reg.pslot : slot_reg;
    assign rd_col  = (state_reg == ST_CTR) ? job_reg.col : x_reg;

    always_ff @(posedge aclk) begin
        if (pop && head.we) line_mem[head.wslot][head.wcol] <= head.pix;
        rd_data_reg <= line_mem[rd_slot][rd_col];
    end

    // distance terms, squared in the next cycle
    assign row_ext  = DV_W'(job_reg.row);
    assign col_ext  = DV_W'(job_reg.col);
    assign crow_ext = DV_W'(circ.center_row);
    assign ccol_ext = DV_W'(circ.center_col);

    always_ff @(posedge aclk) begin
        dr_reg  <= (row_ext > crow_ext) ? row_ext - crow_ext : crow_ext - row_ext;
        dc_reg  <= (col_ext > ccol_ext) ? col_ext - ccol_ext : ccol_ext - col_ext;
        dr2_reg <= dr_reg * dr_reg;
        dc2_reg <= dc_reg * dc_reg;
        rr_reg  <= circ.circle_radius * circ.circle_radius;
    end

    assign rem_shift = {rem_reg[CNT_W-1:0], quo_reg[SUM_W-1]};

    // sequencer
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
            acc_en_reg  <= 1'b0;
        end else begin
            unique case (state_reg)
                ST_IDLE: begin
                    acc_en_reg <= 1'b0;
                    if (pop && head.job) begin
                        job_reg  <= head;
                        slot_reg <= head.tslot;
                        x_reg    <= head.x0;
                        xcnt_reg <= '0;
                        ycnt_reg <= '0;
                        sum_reg  <= '0;
                        cnt_reg  <= '0;
                        state_reg <= ST_READ;
                    end
                end
                ST_READ: begin
                    // walk the box, adding each word in the cycle after its read
                    acc_en_reg <= 1'b1;
                    cnt_reg    <= cnt_reg + CNT_W'(1);
                    if (acc_en_reg) sum_reg <= sum_reg + SUM_W'(rd_data_reg);
                    if (xcnt_reg == job_reg.nx - NY_W'(1)) begin
                        xcnt_reg <= '0;
                        x_reg    <= job_reg.x0;
                        ycnt_reg <= ycnt_reg + NY_W'(1);
                        slot_reg <= (slot_reg == SLOT_W'(LS_ROWS - 1)) ? '0
                                  : slot_reg + SLOT_W'(1);
                        if (ycnt_reg == job_reg.ny - NY_W'(1)) state_reg <= ST_CTR;
                    end else begin
                        xcnt_reg <= xcnt_reg + NY_W'(1);
                        x_reg    <= x_reg + COL_W'(1);
                    end
                end
                ST_CTR: begin
                    acc_en_reg <= 1'b0;
                    if (acc_en_reg) sum_reg <= sum_reg + SUM_W'(rd_data_reg);
                    state_reg <= ST_CWAIT;
                end
                ST_CWAIT: begin
                    center_reg <= rd_data_reg;
                    inside_reg <= (D2_W'(dr2_reg) + D2_W'(dc2_reg)) <= D2_W'(rr_reg);
                    quo_reg    <= sum_reg;
                    rem_reg    <= '0;
                    step_reg   <= '0;
                    state_reg  <= ST_DIV;
                end
                ST_DIV: begin
                    // restoring division, one quotient bit a cycle
                    if (rem_shift >= {1'b0, cnt_reg}) begin
                        rem_reg <= rem_shift - {1'b0, cnt_reg};
                        quo_reg <= {quo_reg[SUM_W-2:0], 1'b1};
                    end else begin
                        rem_reg <= rem_shift;
                        quo_reg <= {quo_reg[SUM_W-2:0], 1'b0};
                    end
                    step_reg <= step_reg + DIV_W'(1);
                    if (step_reg == DIV_W'(SUM_W - 1)) state_reg <= ST_OUT;
                end
                ST_OUT: begin
                    if (!m_valid_reg) begin
                        m_valid_reg <= 1'b1;
                        m_data_reg.out_pixel  <= inside_reg ? quo_reg[7:0] : center_reg;
                        m_data_reg.frame_last <= job_reg.last;
                    end else if (m_ready) begin
                        m_valid_reg <= 1'b0;
                        state_reg   <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end
endmodule
`default_nettype wire

@@ hdl/circle_masked_box_blur.sv @@
// Top level: circle masked box blur on a raster pixel stream
// A result's job is queued R*W+R words after its pixel, then the back end walks its box
// and divides; it takes one job at a time, limited by the single line-store read port
// and the bit-serial divider, and starts no new job before the last result is taken.
// The two-entry queue lets the front accept while the back works.
// Reset (aresetn low, synchronous) restores register defaults and frame position and empties the queue.
`timescale 1ns / 1ps
`default_nettype none
module circle_masked_box_blur
    import cmbb_pkg::*;
#(
    parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = DEF_MAX_HEIGHT,
    parameter int MAX_RADIUS = DEF_MAX_RADIUS
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  s_valid,
    output logic                       s_ready,
    input  wire in_word_t              s_data,
    output logic                       m_valid,
    input  wire logic                  m_ready,
    output out_word_t                  m_data,
    input  wire logic                  cfg_valid,
    output logic                       cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data
);
    localparam int LS_ROWS = 2 * MAX_RADIUS + 2;
    localparam int SLOT_W  = $clog2(LS_ROWS);
    localparam int COL_W   = $clog2(MAX_WIDTH);
    localparam int ROW_W   = $clog2(MAX_HEIGHT + 1);
    localparam int NY_W    = $clog2(2 * MAX_RADIUS + 2);
    localparam int ENTRY_W = 3 + 3 * SLOT_W + 3 * COL_W + 8 + ROW_W + 2 * NY_W;

    circle_cfg_t        circ;
    logic               push, full, pop, empty;
    logic [ENTRY_W-1:0] push_data, pop_data;

    assign cfg_ready = 1'b1;

    cmbb_front #(
        .MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT),
        .MAX_RADIUS(MAX_RADIUS), .ENTRY_W(ENTRY_W)
    ) u_front (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .cfg_valid(cfg_valid), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .circ(circ), .push(push), .push_data(push_data), .full(full)
    );

    cmbb_queue #(.WIDTH(ENTRY_W)) u_queue (
        .aclk(aclk), .aresetn(aresetn),
        .push(push), .push_data(push_data), .full(full),
        .pop(pop), .pop_data(pop_data), .empty(empty)
    );

    cmbb_back #(
        .MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT),
        .MAX_RADIUS(MAX_RADIUS), .ENTRY_W(ENTRY_W)
    ) u_back (
        .aclk(aclk), .aresetn(aresetn), .circ(circ),
        .pop_data(pop_data), .empty(empty), .pop(pop),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data)
    );
endmodule
`default_nettype wire

@@ hdl/cmbb_checker.sv @@
// Port-level checker for the circle masked box blur, bound to the top level
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module cmbb_checker
    import cmbb_pkg::*;
(
    input wire logic      aclk,
    input wire logic      aresetn,
    input wire logic      s_ready,
    input wire logic      m_valid,
    input wire logic      m_ready,
    input wire out_word_t m_data
);
    `ASSERT_RST(a_out_hold, aclk, aresetn, m_valid && !m_ready |=> m_valid, "result word dropped")
    `ASSERT_RST(a_out_stable, aclk, aresetn, m_valid && !m_ready |=> $stable(m_data), "result word changed while stalled")
    `ASSERT_ALL(a_rst_out, aclk, !aresetn |=> !m_valid, "result valid after reset")
    `ASSERT_ALL(a_rst_in, aclk, !aresetn |=> s_ready, "input not ready after reset")
endmodule

bind circle_masked_box_blur cmbb_checker u_checker (
    .aclk(aclk), .aresetn(aresetn), .s_ready(s_ready),
    .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data)
);
`default_nettype wire
